@@ rtl/fard_pkg.sv @@
// Package for the float array reduction block: widths, defaults, special codes.
// No dependencies; imported by float_array_reduce_double_acc.
`timescale 1ns / 1ps
`default_nettype none
package fard_pkg;

    localparam int BLOCK_VOXELS_DEF = 32;
    localparam int MAX_ARRAYS_DEF   = 11;
    localparam int COMPONENTS       = 12;

    localparam int IN_DATA_W  = 48;   // position + word, padded to bytes
    localparam int IN_USER_W  = 4;    // array_index
    localparam int OUT_DATA_W = 48;   // sum_word + out_position, padded
    localparam int PADDR_W    = 3;

    localparam logic [3:0]  COUNT_RESET = 4'd2;
    localparam logic [31:0] QNAN_F      = 32'h7FC0_0000;
    localparam logic [63:0] QNAN_D      = 64'h7FF8_0000_0000_0000;

    // register index, taken from paddr[2]
    localparam logic REG_ARRAY_COUNT = 1'b0;

    // double exponent bias minus float exponent bias
    localparam logic [10:0] BIAS_DIFF = 11'd896;

endpackage
`default_nettype wire

@@ rtl/float_array_reduce_double_acc.sv @@
// Top level of the float array reduction: pipelined double adder, slot memory,
// float/double conversion. Depends on fard_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Element-wise sum of array_count float32 arrays, accumulated in double.
// A word of array 0 is widened and stored in its slot; words of later arrays
// are added to the stored sum, and the last array's sum is rounded to float32
// (nearest even, any NaN as 7FC00000) and sent with its slot. Requests whose
// array index is not below array_count, whose slot lies beyond the block, or
// that arrive while array_count is outside 2..MAX_ARRAYS are dropped.
// Rate: one request per cycle while the output is not stalled and consecutive
// requests hit different slots. A request whose slot matches one still inside
// the adder pipeline (stages 1..7, up to the slot write) is held off until that
// one has written back. The slot memory has one read port (at acceptance) and
// one write port (stage 7); its contents are undefined until array 0 writes a
// slot, so there is no clearing pass.
// Stages: 1 memory read, 2 widen, 3 unpack/swap/specials, 4 align,
// 5 add/subtract, 6 leading-zero count, 7 normalise/round/write back,
// 8 narrowing prep, 9 round to float, then the output register.
// The whole pipeline advances when the output register is free or taken.
module float_array_reduce_double_acc #(
    parameter int BLOCK_VOXELS = fard_pkg::BLOCK_VOXELS_DEF,
    parameter int MAX_ARRAYS   = fard_pkg::MAX_ARRAYS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // APB configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fard_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fard_pkg::IN_DATA_W-1:0]  s_tdata,  // position[8:0], word[40:9]
    input  wire logic [fard_pkg::IN_USER_W-1:0]  s_tuser,  // array_index[3:0]
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [fard_pkg::OUT_DATA_W-1:0] m_tdata   // sum_word[31:0], out_position[40:32]
);
    import fard_pkg::*;

    localparam int SLOTS = BLOCK_VOXELS * COMPONENTS;
    localparam int AW    = $clog2(SLOTS);

    // ---------------- configuration ----------------
    logic [3:0] count_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_ARRAY_COUNT) begin
            count_reg <= pwdata[3:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_ARRAY_COUNT) begin
            prdata = {28'd0, count_reg};
        end
    end

    // ---------------- input decode ----------------
    logic [8:0]  in_pos;
    logic [31:0] in_word;
    logic [3:0]  in_k;
    logic        in_ok;
    logic        en;
    logic        hazard;
    logic        accept;

    assign in_pos  = s_tdata[8:0];
    assign in_word = s_tdata[40:9];
    assign in_k    = s_tuser;

    assign in_ok = (count_reg >= 4'd2) && ({28'd0, count_reg} <= MAX_ARRAYS)
                && (in_k < count_reg) && ({23'd0, in_pos} < SLOTS);

    // pipeline stage registers
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic        first1_reg, first2_reg;
    logic        last1_reg, last2_reg, last3_reg, last4_reg, last5_reg, last6_reg, last7_reg;
    logic [8:0]  pos1_reg, pos2_reg, pos3_reg, pos4_reg, pos5_reg, pos6_reg, pos7_reg;
    logic [8:0]  pos8_reg, pos9_reg;
    logic [31:0] word1_reg;
    logic [63:0] rd1_reg;

    assign en = !m_tvalid || m_tready;

    // a slot still on its way to write back must not be read again yet
    assign hazard = (v1_reg && pos1_reg == in_pos) || (v2_reg && pos2_reg == in_pos)
                 || (v3_reg && pos3_reg == in_pos) || (v4_reg && pos4_reg == in_pos)
                 || (v5_reg && pos5_reg == in_pos) || (v6_reg && pos6_reg == in_pos)
                 || (v7_reg && pos7_reg == in_pos);

    assign s_tready = en && !hazard;
    assign accept   = s_tvalid && s_tready;

    // ---------------- slot memory ----------------
    logic [63:0] sums_mem [SLOTS];
    logic [63:0] res7_next;
    logic [63:0] res7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rd1_reg <= sums_mem[AW'(in_pos)];
        end
    end

    always_ff @(posedge aclk) begin
        if (en && v7_reg) begin
            sums_mem[AW'(pos7_reg)] <= res7_reg;
        end
    end

    // ---------------- stage 2: widen float to double ----------------
    logic [63:0] wide_next;

    always_comb begin
        logic [7:0]  ef;
        logic [22:0] ff;
        logic [4:0]  lz;
        logic [22:0] fsh;
        ef  = word1_reg[30:23];
        ff  = word1_reg[22:0];
        lz  = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (ff[i]) lz = 5'(22 - i);
        end
        fsh = ff << (lz + 5'd1);
        if (ef == 8'hFF) begin
            wide_next = {word1_reg[31], 11'h7FF, ff, 29'd0};
        end else if (ef == 8'd0 && ff == 23'd0) begin
            wide_next = {word1_reg[31], 63'd0};
        end else if (ef == 8'd0) begin
            wide_next = {word1_reg[31], BIAS_DIFF - {6'd0, lz}, fsh, 29'd0};
        end else begin
            wide_next = {word1_reg[31], {3'd0, ef} + BIAS_DIFF, ff, 29'd0};
        end
    end

    // ---------------- stage 3: unpack, order, specials ----------------
    logic [63:0] a2_reg, b2_reg;
    logic        byp3_next;
    logic [63:0] bval3_next;
    logic        sbig3_next, sub3_next;
    logic [10:0] ebig3_next, diff3_next;
    logic [52:0] mbig3_next, msml3_next;

    always_comb begin
        logic        nan_a, nan_b, inf_a, inf_b;
        logic        a_big;
        logic [10:0] ea, eb;
        ea    = a2_reg[62:52];
        eb    = b2_reg[62:52];
        nan_a = (ea == 11'h7FF) && (a2_reg[51:0] != 52'd0);
        nan_b = (eb == 11'h7FF) && (b2_reg[51:0] != 52'd0);
        inf_a = (ea == 11'h7FF) && (a2_reg[51:0] == 52'd0);
        inf_b = (eb == 11'h7FF) && (b2_reg[51:0] == 52'd0);
        a_big = a2_reg[62:0] >= b2_reg[62:0];

        byp3_next  = 1'b1;
        bval3_next = b2_reg;
        if (first2_reg) begin
            bval3_next = b2_reg;
        end else if (nan_a || nan_b || (inf_a && inf_b && a2_reg[63] != b2_reg[63])) begin
            bval3_next = QNAN_D;
        end else if (inf_a) begin
            bval3_next = a2_reg;
        end else if (inf_b) begin
            bval3_next = b2_reg;
        end else begin
            byp3_next = 1'b0;
        end

        sub3_next = a2_reg[63] != b2_reg[63];
        if (a_big) begin
            sbig3_next = a2_reg[63];
            ebig3_next = ea;
            diff3_next = ea - eb;
            mbig3_next = {ea != 11'd0, a2_reg[51:0]};
            msml3_next = {eb != 11'd0, b2_reg[51:0]};
        end else begin
            sbig3_next = b2_reg[63];
            ebig3_next = eb;
            diff3_next = eb - ea;
            mbig3_next = {eb != 11'd0, b2_reg[51:0]};
            msml3_next = {ea != 11'd0, a2_reg[51:0]};
        end
    end

    // ---------------- stage 4: align smaller operand ----------------
    logic        byp3_reg, sbig3_reg, sub3_reg;
    logic [63:0] bval3_reg;
    logic [10:0] ebig3_reg, diff3_reg;
    logic [52:0] mbig3_reg, msml3_reg;
    logic [55:0] al4_next;

    always_comb begin
        logic [5:0]   dc;
        logic [111:0] t;
        dc = (diff3_reg >= 11'd56) ? 6'd56 : diff3_reg[5:0];
        t  = {msml3_reg, 3'd0, 56'd0} >> dc;
        al4_next = t[111:56] | {55'd0, |t[55:0]};
    end

    // ---------------- stage 5: add / subtract ----------------
    logic        byp4_reg, sbig4_reg, sub4_reg;
    logic [63:0] bval4_reg;
    logic [10:0] ebig4_reg;
    logic [52:0] mbig4_reg;
    logic [55:0] al4_reg;
    logic [56:0] sum5_next;

    assign sum5_next = sub4_reg ? ({1'b0, mbig4_reg, 3'd0} - {1'b0, al4_reg})
                                : ({1'b0, mbig4_reg, 3'd0} + {1'b0, al4_reg});

    // ---------------- stage 6: leading-zero count ----------------
    logic        byp5_reg, sbig5_reg, sub5_reg;
    logic [63:0] bval5_reg;
    logic [10:0] ebig5_reg;
    logic [56:0] sum5_reg;
    logic [5:0]  lz6_next;

    always_comb begin
        lz6_next = 6'd0;
        for (int i = 0; i < 57; i++) begin
            if (sum5_reg[i]) lz6_next = 6'(56 - i);
        end
    end

    // ---------------- stage 7: normalise, round, write back ----------------
    logic        byp6_reg, sbig6_reg, sub6_reg;
    logic [63:0] bval6_reg;
    logic [10:0] ebig6_reg;
    logic [56:0] sum6_reg;
    logic [5:0]  lz6_reg;

    always_comb begin
        logic [56:0] n;
        logic [11:0] e;
        logic        rup;
        logic [62:0] mag;
        n   = sum6_reg << lz6_reg;
        e   = {1'b0, ebig6_reg} + 12'd1 - {6'd0, lz6_reg};
        rup = n[3] && (n[4] || (n[2:0] != 3'd0));
        mag = {e[10:0], n[55:4]} + {62'd0, rup};
        if (byp6_reg) begin
            res7_next = bval6_reg;
        end else if (sum6_reg == 57'd0) begin
            // exact cancellation gives +0; two zeros of one sign keep it
            res7_next = {sub6_reg ? 1'b0 : sbig6_reg, 63'd0};
        end else begin
            res7_next = {sbig6_reg, mag};
        end
    end

    // ---------------- stage 8: narrowing prep ----------------
    logic [63:0] d8_reg;
    logic        nan9_next, inf9_next, zero9_next, tiny9_next;
    logic [7:0]  ef9_next;
    logic [5:0]  rc9_next;

    always_comb begin
        logic [10:0]        ed;
        logic signed [12:0] efl;
        logic [11:0]        r;
        ed  = d8_reg[62:52];
        efl = $signed({2'd0, ed}) - $signed({2'd0, BIAS_DIFF});
        r   = 12'd926 - {1'b0, ed};
        nan9_next  = (ed == 11'h7FF) && (d8_reg[51:0] != 52'd0);
        inf9_next  = (ed == 11'h7FF && d8_reg[51:0] == 52'd0) || (efl >= 13'sd255);
        zero9_next = (ed == 11'd0);
        tiny9_next = (efl <= 13'sd0);
        ef9_next   = efl[7:0];
        rc9_next   = (r > 12'd60) ? 6'd60 : r[5:0];
    end

    // ---------------- stage 9: round to float ----------------
    logic        sign9_reg, nan9_reg, inf9_reg, zero9_reg, tiny9_reg;
    logic [7:0]  ef9_reg;
    logic [51:0] fr9_reg;
    logic [5:0]  rc9_reg;
    logic [31:0] fword_next;

    always_comb begin
        logic [108:0] t;
        logic [22:0]  q;
        logic         g, st, rup;
        logic [30:0]  pk;
        if (tiny9_reg) begin
            t  = {1'b1, fr9_reg, 56'd0} >> rc9_reg;
            q  = t[78:56];
            g  = t[55];
            st = t[54:0] != 55'd0;
            rup = g && (st || q[0]);
            pk = {8'd0, q} + {30'd0, rup};
        end else begin
            t  = 109'd0;
            q  = fr9_reg[51:29];
            g  = fr9_reg[28];
            st = fr9_reg[27:0] != 28'd0;
            rup = g && (st || q[0]);
            pk = {ef9_reg, q} + {30'd0, rup};
        end
        if (nan9_reg) begin
            fword_next = QNAN_F;
        end else if (inf9_reg) begin
            fword_next = {sign9_reg, 8'hFF, 23'd0};
        end else if (zero9_reg) begin
            fword_next = {sign9_reg, 31'd0};
        end else begin
            fword_next = {sign9_reg, pk};
        end
    end

    // ---------------- pipeline registers: valid bits ----------------
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            v9_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= accept && in_ok;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            v8_reg      <= v7_reg && last7_reg;
            v9_reg      <= v8_reg;
            m_valid_reg <= v9_reg;
        end
    end

    // ---------------- pipeline registers: payload ----------------
    logic [31:0] sum_word_reg;
    logic [8:0]  out_pos_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            first1_reg <= in_k == 4'd0;
            last1_reg  <= in_k == count_reg - 4'd1;
            pos1_reg   <= in_pos;
            word1_reg  <= in_word;

            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
            pos2_reg   <= pos1_reg;
            a2_reg     <= rd1_reg;
            b2_reg     <= wide_next;

            last3_reg  <= last2_reg;
            pos3_reg   <= pos2_reg;
            byp3_reg   <= byp3_next;
            bval3_reg  <= bval3_next;
            sbig3_reg  <= sbig3_next;
            sub3_reg   <= sub3_next;
            ebig3_reg  <= ebig3_next;
            diff3_reg  <= diff3_next;
            mbig3_reg  <= mbig3_next;
            msml3_reg  <= msml3_next;

            last4_reg  <= last3_reg;
            pos4_reg   <= pos3_reg;
            byp4_reg   <= byp3_reg;
            bval4_reg  <= bval3_reg;
            sbig4_reg  <= sbig3_reg;
            sub4_reg   <= sub3_reg;
            ebig4_reg  <= ebig3_reg;
            mbig4_reg  <= mbig3_reg;
            al4_reg    <= al4_next;

            last5_reg  <= last4_reg;
            pos5_reg   <= pos4_reg;
            byp5_reg   <= byp4_reg;
            bval5_reg  <= bval4_reg;
            sbig5_reg  <= sbig4_reg;
            sub5_reg   <= sub4_reg;
            ebig5_reg  <= ebig4_reg;
            sum5_reg   <= sum5_next;

            last6_reg  <= last5_reg;
            pos6_reg   <= pos5_reg;
            byp6_reg   <= byp5_reg;
            bval6_reg  <= bval5_reg;
            sbig6_reg  <= sbig5_reg;
            sub6_reg   <= sub5_reg;
            ebig6_reg  <= ebig5_reg;
            sum6_reg   <= sum5_reg;
            lz6_reg    <= lz6_next;

            last7_reg  <= last6_reg;
            pos7_reg   <= pos6_reg;
            res7_reg   <= res7_next;

            d8_reg     <= res7_reg;
            pos8_reg   <= pos7_reg;

            pos9_reg   <= pos8_reg;
            sign9_reg  <= d8_reg[63];
            nan9_reg   <= nan9_next;
            inf9_reg   <= inf9_next;
            zero9_reg  <= zero9_next;
            tiny9_reg  <= tiny9_next;
            ef9_reg    <= ef9_next;
            fr9_reg    <= d8_reg[51:0];
            rc9_reg    <= rc9_next;

            sum_word_reg <= fword_next;
            out_pos_reg  <= pos9_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_pos_reg, sum_word_reg};

endmodule
`default_nettype wire

@@ tb/float_array_reduce_double_acc_tb.sv @@
// Testbench for float_array_reduce_double_acc: directed table, then sequences of
// requests per array count, checked against a bit-exact float/double predictor.
// Depends on fard_pkg and the block's RTL only.
`timescale 1ns / 1ps
module float_array_reduce_double_acc_tb;
    import fard_pkg::*;

    localparam int SLOTS       = BLOCK_VOXELS_DEF * COMPONENTS;
    localparam int TIMEOUT_CYC = 400000;
    localparam int DRAIN_CYC   = 14;    // pipeline latency plus margin
    localparam int HOLD_CYC    = 300;   // length of the long receiver stall
    localparam logic [3:0] FIRST_ARRAY = 4'd0;   // array 0 starts a sum
    localparam logic [PADDR_W-1:0] ADDR_ARRAY_COUNT = {REG_ARRAY_COUNT, 2'b00};

    typedef struct packed {
        logic [31:0] sum_word;
        logic [8:0]  position;
    } sum_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;    // position[8:0], word[40:9]
    logic [IN_USER_W-1:0]  s_tuser = '0;    // array_index[3:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // sum_word[31:0], out_position[40:32]

    float_array_reduce_double_acc dut (.*);

    always #10 aclk = ~aclk;

    // ---------------- predictor state ----------------
    logic [63:0] slot_sum [SLOTS];
    bit          slot_written [SLOTS];
    logic [3:0]  array_count_q = COUNT_RESET;
    sum_t        expected_sums [$];
    int          err_count = 0;
    int          sums_seen = 0;
    int          requests_sent = 0;
    bit          idle_on = 1'b1;
    bit          long_hold = 1'b0;  // set by the stimulus to start the long stall
    int          hold_len = 0;      // cycles of the long stall so far

    task automatic report(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // float32 -> double, exact, subnormals normalised
    function automatic logic [63:0] widen(input logic [31:0] f);
        logic [23:0] mm;
        logic [10:0] ed;
        if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'b0};
        if (f[30:23] == 8'h00) begin
            if (f[22:0] == 0) return {f[31], 63'b0};
            mm = {1'b0, f[22:0]};
            ed = 11'd897;
            while (!mm[23]) begin
                mm = mm << 1;
                ed = ed - 11'd1;
            end
            return {f[31], ed, mm[22:0], 29'b0};
        end
        return {f[31], {3'b0, f[30:23]} + BIAS_DIFF, f[22:0], 29'b0};
    endfunction

    // double -> float32, round to nearest even; any NaN becomes the quiet NaN
    function automatic logic [31:0] narrow(input logic [63:0] d);
        int          e, sh;
        logic [63:0] sig, kept, rem, half, base;
        bit          up;
        if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? QNAN_F : {d[63], 31'h7F800000};
        if (d[62:52] == 11'h000) return {d[63], 31'b0};   // double subnormal: far below float
        e = int'(d[62:52]);
        e = e - 1023;
        if (e > 127) return {d[63], 31'h7F800000};
        sig = {11'b0, 1'b1, d[51:0]};
        sh = 29 + ((e < -126) ? (-126 - e) : 0);
        if (sh >= 63) return {d[63], 31'b0};
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        up   = (rem > half) || (rem == half && kept[0]);
        // hidden bit of a normal result lifts the exponent by one; carries spill over
        base = (e >= -126) ? (64'(e + 126) << 23) : 64'd0;
        kept = kept + base + 64'(up);
        return {d[63], kept[30:0]};
    endfunction

    // applies one accepted request to the slot store; returns 1 with the sum if one is due
    function automatic bit reduce_request(input logic [3:0] k, input logic [8:0] pos,
                                          input logic [31:0] word, output sum_t res);
        real acc;
        res = '0;
        if (array_count_q < 2 || array_count_q > MAX_ARRAYS_DEF) return 0;
        if (k >= array_count_q || pos >= SLOTS) return 0;
        if (k == FIRST_ARRAY) begin
            slot_sum[pos] = widen(word);
            slot_written[pos] = 1'b1;
            return 0;
        end
        acc = $bitstoreal(slot_sum[pos]) + $bitstoreal(widen(word));
        slot_sum[pos] = $realtobits(acc);
        if (k != array_count_q - 1) return 0;
        res.sum_word = narrow(slot_sum[pos]);
        res.position = pos;
        return 1;
    endfunction

    // ---------------- result side ----------------
    int rx_idle = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sums_seen++;
            if (expected_sums.size() == 0) begin
                report($sformatf("unexpected sum %h at slot %0d", m_tdata[31:0], m_tdata[40:32]));
            end else begin
                if (m_tdata[31:0] !== expected_sums[0].sum_word)
                    report($sformatf("slot %0d sum %h, want %h", expected_sums[0].position,
                                     m_tdata[31:0], expected_sums[0].sum_word));
                if (m_tdata[40:32] !== expected_sums[0].position)
                    report($sformatf("position %0d, want %0d", m_tdata[40:32],
                                     expected_sums[0].position));
                void'(expected_sums.pop_front());
            end
        end
        // one assignment to m_tready per edge
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold && hold_len < HOLD_CYC) begin
            hold_len <= hold_len + 1;
            m_tready <= 1'b0;
        end else if (rx_idle > 0) begin
            rx_idle  <= rx_idle - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rx_idle  <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------- watchdog ----------------
    int cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYC) begin
            $display("timeout after %0d cycles, %0d sums outstanding", cycles,
                     expected_sums.size());
            $display("float_array_reduce_double_acc_tb: FAIL");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    // offer one request and wait for it to be taken; a typed sum overrides the predictor
    task automatic send_request(input logic [3:0] k, input logic [8:0] pos,
                                input logic [31:0] word, input bit typed,
                                input logic [31:0] typed_sum);
        sum_t res;
        bit   due;
        s_tuser  <= k;
        s_tdata  <= {7'b0, word, pos};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        due = reduce_request(k, pos, word, res);
        if (typed) begin
            if (!due) report($sformatf("directed request at slot %0d predicts no sum", pos));
            res.sum_word = typed_sum;
            res.position = pos;
            expected_sums.push_back(res);
        end else if (due) begin
            expected_sums.push_back(res);
        end
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // idle between phases: all sums in, then the pipeline emptied of dropped requests
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_array_count(input logic [3:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_ARRAY_COUNT; pwdata <= {28'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        array_count_q = value;
        // read it back
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[3:0] !== value)
            report($sformatf("array_count reads %h, wrote %h", prdata[3:0], value));
        psel <= 1'b0; penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_word();
        logic [31:0] specials [9] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
            32'hFF80_0000, 32'h7FC0_0000, 32'h7F7F_FFFF, 32'h0000_0001,
            32'h807F_FFFF, 32'hFFFF_FFFF};
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return specials[$urandom_range(0, 8)];
            2: return {1'($urandom), 8'h00, 23'($urandom)};
            default: return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
        endcase
    endfunction

    // ---------------- directed table (array_count at reset value 2) ----------------
    // {array_index, position, word, typed, expected sum}
    localparam int DIR_ROWS = 23;
    localparam logic [77:0] DIRECTED [DIR_ROWS] = '{
        {4'd0,  9'd0,   32'h3F80_0000, 1'b0, 32'h0},
        {4'd1,  9'd0,   32'h3F80_0000, 1'b1, 32'h4000_0000},   // 1 + 1
        {4'd0,  9'd383, 32'h7F7F_FFFF, 1'b0, 32'h0},
        {4'd1,  9'd383, 32'h7F7F_FFFF, 1'b1, 32'h7F80_0000},   // overflows to inf
        {4'd0,  9'd1,   32'h7FC0_0001, 1'b0, 32'h0},
        {4'd1,  9'd1,   32'h0000_0000, 1'b1, QNAN_F},          // NaN payload dropped
        {4'd0,  9'd2,   32'h7F80_0000, 1'b0, 32'h0},
        {4'd1,  9'd2,   32'hFF80_0000, 1'b1, QNAN_F},          // inf - inf
        {4'd0,  9'd3,   32'h0000_0001, 1'b0, 32'h0},
        {4'd1,  9'd3,   32'h0000_0001, 1'b1, 32'h0000_0002},   // subnormals
        {4'd0,  9'd4,   32'h8000_0000, 1'b0, 32'h0},
        {4'd1,  9'd4,   32'h8000_0000, 1'b1, 32'h8000_0000},   // -0 + -0
        {4'd1,  9'd4,   32'h0000_0000, 1'b1, 32'h0000_0000},   // -0 + +0
        {4'd2,  9'd5,   32'hFFFF_FFFF, 1'b0, 32'h0},           // index beyond count
        {4'd0,  9'd384, 32'h1234_5678, 1'b0, 32'h0},           // slot beyond block
        {4'd1,  9'd511, 32'h3F80_0000, 1'b0, 32'h0},
        {4'd15, 9'd0,   32'h0000_0000, 1'b0, 32'h0},
        {4'd1,  9'd0,   32'h3F80_0000, 1'b1, 32'h4040_0000},   // retained sum 2 + 1
        {4'd0,  9'd6,   32'h3F80_0000, 1'b0, 32'h0},
        {4'd1,  9'd6,   32'h3380_0000, 1'b1, 32'h3F80_0000},   // tie, rounds to even
        {4'd0,  9'd7,   32'hFF7F_FFFF, 1'b0, 32'h0},
        {4'd1,  9'd7,   32'hFFFF_FFFF, 1'b1, QNAN_F},
        {4'd1,  9'd3,   32'h807F_FFFF, 1'b1, 32'h807F_FFFD}    // sign flips, stays subnormal
    };

    // ---------------- phases of random sequences ----------------
    localparam int PHASES = 8;
    localparam logic [3:0] PHASE_COUNT [PHASES] = '{4'd11, 4'd3, 4'd15, 4'd0,
                                                    4'd7, 4'd2, 4'd5, 4'd11};
    localparam int PHASE_ITEMS [PHASES] = '{160, 180, 30, 20, 180, 160, 180, 200};

    initial begin
        logic [8:0]  run_pos [4];
        logic [3:0]  run_k [4];
        logic [3:0]  k;
        logic [8:0]  pos;
        int          j;
        bit          count_ok;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_request(DIRECTED[r][77:74], DIRECTED[r][73:65], DIRECTED[r][64:33],
                         DIRECTED[r][32], DIRECTED[r][31:0]);
            sender_gap();
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_array_count(PHASE_COUNT[p]);
            idle_on = (p != PHASES - 1);
            count_ok = PHASE_COUNT[p] >= 2 && PHASE_COUNT[p] <= MAX_ARRAYS_DEF;
            for (int s = 0; s < 4; s++) begin
                run_pos[s] = 9'($urandom_range(0, SLOTS - 1));
                run_k[s]   = FIRST_ARRAY;
            end
            // receiver stalls for a long stretch while requests keep coming
            if (p == 1) long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                if (count_ok && $urandom_range(0, 99) < 85) begin
                    // well-formed: four interleaved sums, each array in turn
                    j = $urandom_range(0, 3);
                    k = run_k[j];
                    pos = run_pos[j];
                    run_k[j] = run_k[j] + 4'd1;
                    if (run_k[j] >= PHASE_COUNT[p]) begin
                        run_k[j]   = FIRST_ARRAY;
                        run_pos[j] = 9'($urandom_range(0, SLOTS - 1));
                    end
                end else begin
                    k = 4'($urandom_range(0, 15));
                    pos = 9'($urandom_range(0, 511));
                    // never add into a slot that has not been started
                    if (count_ok && k != FIRST_ARRAY && k < PHASE_COUNT[p] && pos < SLOTS
                            && !slot_written[pos])
                        k = FIRST_ARRAY;
                end
                send_request(k, pos, pick_word(), 1'b0, 32'h0);
                if (p != 1) sender_gap();
            end
        end

        wait_idle();
        $display("covered %0d requests and %0d sums over %0d array counts,",
                 requests_sent, sums_seen, PHASES + 1);
        $display("including dropped requests, invalid counts and a long output stall");
        if (err_count == 0) begin
            $display("float_array_reduce_double_acc_tb: PASS");
        end else begin
            $display("%0d mismatches", err_count);
            $display("float_array_reduce_double_acc_tb: FAIL");
        end
        $finish;
    end

endmodule
